@@ rtl/rhr_pkg.sv @@
// Package for the RGB555 lightness and hue recolour unit.
// Holds field widths, register indices, the queued item type and the channel widening.
// No dependencies.
`timescale 1ns / 1ps

package rhr_pkg;

	localparam int FRAC_BITS_DEF = 12;

	localparam int COLOR_W = 15;
	localparam int CHAN_W  = 8;
	localparam int SUM_W   = 9;
	localparam int HUE_W   = 12;
	localparam int SAT_W   = 13;
	localparam int GAIN_W  = 13;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE  = 2'd0,
		CFG_SAT  = 2'd1,
		CFG_GAIN = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  sat;
		logic [GAIN_W-1:0] gain;
	} rhr_cfg_t;

	typedef struct packed {
		logic             grey;
		logic [SUM_W-1:0] sum;
	} rhr_item_t;

	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] x);
		return {x, x[4:2]};
	endfunction

endpackage

@@ rtl/rgb555_lightness_hue_recolor_unit.sv @@
// Top level of the RGB555 lightness and hue recolour unit: configuration registers and wiring.
// Instantiates rhr_front, rhr_queue and rhr_back; depends on rhr_pkg.
`timescale 1ns / 1ps

// Takes one RGB555 colour per item and returns the colour rebuilt from the configured hue and
// saturation with its lightness scaled by the configured gain. One item is accepted every clock
// cycle while the output is taken; each item passes through the front register, loaded at the
// edge that accepts it, then one queue slot and the seven-stage back pipeline, whose last stage
// is the output register. A four-item queue between front and back absorbs output stalls.
// Configuration writes take effect at once and belong in idle periods.
module rgb555_lightness_hue_recolor_unit import rhr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // color_in [14:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	rhr_cfg_t          cfg_q;
	rhr_item_t         f_item, q_item;
	logic              push, pop, full, empty;
	logic [CHAN_W-1:0] red, green, blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue  <= '0;
			cfg_q.sat  <= '0;
			cfg_q.gain <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_HUE:  cfg_q.hue  <= cfg_data[HUE_W-1:0];
				CFG_SAT:  cfg_q.sat  <= cfg_data[SAT_W-1:0];
				CFG_GAIN: cfg_q.gain <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	rhr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.color    (s_tdata[COLOR_W-1:0]),
		.sat      (cfg_q.sat),
		.q_full   (full),
		.push     (push),
		.item     (f_item)
	);

	rhr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.full   (full),
		.pop    (pop),
		.dout   (q_item),
		.empty  (empty)
	);

	rhr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (q_item),
		.avail     (!empty),
		.take      (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_tdata = {blue, green, red};

endmodule

@@ rtl/rhr_front.sv @@
// Front part of the recolour unit: accepts colours, widens the channels and forms max + min.
// Also marks items that take the grey path. Depends on rhr_pkg.
`timescale 1ns / 1ps

module rhr_front import rhr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] color,
	input  logic [SAT_W-1:0]   sat,
	input  logic               q_full,
	output logic               push,
	output rhr_item_t          item
);

	localparam int ONE      = 1 << FRAC_BITS;
	localparam int GREY_LIM = (ONE + 999) / 1000;

	logic               valid_q;
	logic [COLOR_W-1:0] color_q;
	logic               adv;
	logic [CHAN_W-1:0]  r, g, b, mx, mn;

	assign adv      = !valid_q || !q_full;
	assign in_ready = adv;
	assign push     = valid_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			color_q <= color;
		end
	end

	always_comb begin
		r  = widen5(color_q[4:0]);
		g  = widen5(color_q[9:5]);
		b  = widen5(color_q[14:10]);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		item.sum  = {1'b0, mx} + {1'b0, mn};
		item.grey = (sat < SAT_W'(GREY_LIM));
	end

endmodule

@@ rtl/rhr_queue.sv @@
// Short queue between the front and back parts of the recolour unit.
// Holds classified items so that each side can stall on its own. Depends on rhr_pkg.
`timescale 1ns / 1ps

module rhr_queue import rhr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rhr_item_t din,
	output logic      full,
	input  logic      pop,
	output rhr_item_t dout,
	output logic      empty
);

	rhr_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

@@ rtl/rhr_back.sv @@
// Back part of the recolour unit: seven-stage pipeline from max + min to the output channels.
// Lightness, gain, HSL rebuild and rounding, with the output register last. Depends on rhr_pkg.
`timescale 1ns / 1ps

module rhr_back import rhr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rhr_cfg_t          cfg,
	input  rhr_item_t         item,
	input  logic              avail,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue
);

	localparam int F     = FRAC_BITS;
	localparam int NW    = F + 9;
	localparam int MW    = F + 1;
	localparam int LW    = F + 1;
	localparam int NLW   = 13;
	localparam int LSW   = 27 - F;
	localparam int QW    = ((LSW > 14) ? LSW : 14) + 3;
	localparam int CW    = QW + F + 3;
	localparam int TW    = F + 4;
	localparam int GPW   = F + 21;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << NW) / 510);
	localparam logic [TW-1:0] ONE_T = TW'(1) << F;
	localparam logic [TW-1:0] SIX_T = TW'(6) << F;

	// Stage valids and pipeline registers.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic grey_s1, grey_s2, grey_s3, grey_s4, grey_s5, grey_s6;
	logic [NW-1:0]            num_s1;
	logic [LW-1:0]            qe_s1;
	logic [LW-1:0]            l_s2;
	logic [NLW-1:0]           nl_s3, nl_s4;
	logic [LSW-1:0]           ls_s4;
	logic [CHAN_W-1:0]        gv_s4, gv_s5, gv_s6;
	logic signed [QW-1:0]     p_s5, d_s5;
	logic signed [CW-1:0]     cr_s6, cg_s6, cb_s6;
	logic [CHAN_W-1:0]        red_s7, green_s7, blue_s7;

	logic                     en;
	logic [NW-1:0]            num;
	logic [NW+MW-1:0]         rprod;
	logic [F+9:0]             qm, rem;
	logic [LW-1:0]            l;
	logic [F+13:0]            lg;
	logic [26:0]              ns;
	logic [GPW-1:0]           gp;
	logic [GPW-F-1:0]         gvf;
	logic [CHAN_W-1:0]        gv;
	logic signed [QW-1:0]     nl_x, ls_x, s_x, q, p, d;
	logic [HUE_W+F-1:0]       hue_w;
	logic [TW-1:0]            h6, t_r, t_g, t_b;
	logic [F:0]               f_r, f_g, f_b;
	logic signed [QW+F+1:0]   prd_r, prd_g, prd_b;
	logic signed [CW-1:0]     c_r, c_g, c_b;

	function automatic logic [TW-1:0] wrap6(input logic [TW-1:0] x);
		return (x >= SIX_T) ? x - SIX_T : x;
	endfunction

	function automatic logic [F:0] hue_factor(input logic [TW-1:0] t);
		logic [TW-1:0] rest;
		rest = (ONE_T << 2) - t;
		if (t < ONE_T) begin
			return t[F:0];
		end else if (t < (ONE_T + (ONE_T << 1))) begin
			return ONE_T[F:0];
		end else if (t < (ONE_T << 2)) begin
			return rest[F:0];
		end else begin
			return '0;
		end
	endfunction

	function automatic logic [CHAN_W-1:0] sat_chan(input logic signed [CW-1:0] c);
		logic [CW+7:0] cu, vf, sh;
		cu = (CW+8)'(c);
		vf = cu * (CW+8)'(255) + ((CW+8)'(1) << (2 * F - 1));
		sh = vf >> (2 * F);
		if (c <= 0) begin
			return '0;
		end else if (sh > (CW+8)'(255)) begin
			return '1;
		end else begin
			return sh[CHAN_W-1:0];
		end
	endfunction

	assign en        = !vld_s7 || out_ready;
	assign take      = avail && en;
	assign out_valid = vld_s7;
	assign red       = red_s7;
	assign green     = green_s7;
	assign blue      = blue_s7;

	always_comb begin
		// Lightness: (sum * ONE + 255) / 510 by reciprocal, then one correction step.
		num   = {item.sum, {F{1'b0}}} + NW'(255);
		rprod = (NW+MW)'(num) * (NW+MW)'(RECIP);
		qm    = (F+10)'(qe_s1) * (F+10)'(510);
		rem   = {1'b0, num_s1} - qm;
		l     = qe_s1 + LW'(rem >= (F+10)'(510));

		lg = (F+14)'(l_s2) * (F+14)'(cfg.gain) + ((F+14)'(1) << (F - 1));

		ns  = 27'(nl_s3) * 27'(cfg.sat) + (27'(1) << (F - 1));
		gp  = GPW'(nl_s3) * GPW'(255);
		gvf = gp[GPW-1:F];
		gv  = (gvf > (GPW-F)'(255)) ? '1 : gvf[CHAN_W-1:0];

		nl_x = $signed({{(QW-NLW){1'b0}}, nl_s4});
		ls_x = $signed({{(QW-LSW){1'b0}}, ls_s4});
		s_x  = $signed({{(QW-SAT_W){1'b0}}, cfg.sat});
		if (int'(nl_s4) < (1 << (F - 1))) begin
			q = nl_x + ls_x;
		end else begin
			q = nl_x + s_x - ls_x;
		end
		p = (nl_x <<< 1) - q;
		d = q - p;

		hue_w = {{F{1'b0}}, cfg.hue};
		h6    = (TW'(hue_w[F-1:0]) << 2) + (TW'(hue_w[F-1:0]) << 1);
		t_r   = wrap6(h6 + (ONE_T << 1));
		t_g   = h6;
		t_b   = wrap6(h6 + (ONE_T << 2));
		f_r   = hue_factor(t_r);
		f_g   = hue_factor(t_g);
		f_b   = hue_factor(t_b);
		prd_r = d_s5 * $signed({1'b0, f_r});
		prd_g = d_s5 * $signed({1'b0, f_g});
		prd_b = d_s5 * $signed({1'b0, f_b});
		c_r   = (CW'(p_s5) <<< F) + CW'(prd_r);
		c_g   = (CW'(p_s5) <<< F) + CW'(prd_g);
		c_b   = (CW'(p_s5) <<< F) + CW'(prd_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= avail;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= num;
			qe_s1   <= rprod[NW+MW-1:NW];
			grey_s1 <= item.grey;

			l_s2    <= l;
			grey_s2 <= grey_s1;

			nl_s3   <= lg[F+12:F];
			grey_s3 <= grey_s2;

			nl_s4   <= nl_s3;
			ls_s4   <= ns[26:F];
			gv_s4   <= gv;
			grey_s4 <= grey_s3;

			p_s5    <= p;
			d_s5    <= d;
			gv_s5   <= gv_s4;
			grey_s5 <= grey_s4;

			cr_s6   <= c_r;
			cg_s6   <= c_g;
			cb_s6   <= c_b;
			gv_s6   <= gv_s5;
			grey_s6 <= grey_s5;

			red_s7   <= grey_s6 ? gv_s6 : sat_chan(cr_s6);
			green_s7 <= grey_s6 ? gv_s6 : sat_chan(cg_s6);
			blue_s7  <= grey_s6 ? gv_s6 : sat_chan(cb_s6);
		end
	end

endmodule

@@ sim/tb_rgb555_lightness_hue_recolor_unit.sv @@
// Self-checking testbench for rgb555_lightness_hue_recolor_unit: directed table, then random items.
// Depends on rhr_pkg and the RTL of the unit; reads no files and needs no arguments.
`timescale 1ns / 1ps

module tb_rgb555_lightness_hue_recolor_unit;
	import rhr_pkg::*;

	localparam int     FRAC        = FRAC_BITS_DEF;
	localparam longint UNIT        = longint'(1) << FRAC;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     SETTLE      = 16;
	localparam int     RANDOM_SETS = 8;
	localparam int     SET_ITEMS   = 110;
	localparam int     BURST_ITEMS = 40;
	localparam int     HOLD_CYCLES = 250;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} recolor_rgb_t;

	typedef struct {
		logic [HUE_W-1:0]   hue;
		logic [SAT_W-1:0]   sat;
		logic [GAIN_W-1:0]  gain;
		bit                 stray;
		logic [COLOR_W-1:0] color;
		bit                 typed;
		recolor_rgb_t       rgb;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // color_in [14:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;   // red_out [7:0], green_out [15:8], blue_out [23:16]
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [HUE_W-1:0]  hue_reg;
	logic [SAT_W-1:0]  sat_reg;
	logic [GAIN_W-1:0] gain_reg;

	recolor_rgb_t  pending_rgb[$];
	recolor_rgb_t  oldest_rgb;
	directed_row_t directed_rows[21];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycle_count;
	int mismatches;
	int items_sent;
	int results_seen;
	int reg_writes;

	rgb555_lightness_hue_recolor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint widen_channel(logic [4:0] x);
		return (longint'(x) << 3) | (longint'(x) >> 2);
	endfunction

	function automatic logic [CHAN_W-1:0] q2f_to_byte(longint c);
		longint v;
		if (c <= 0)
			return '0;
		v = (c * 255 + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
		return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
	endfunction

	function automatic logic [CHAN_W-1:0] hue_channel(longint p, longint q, longint h6,
		longint off);
		longint t6;
		longint c;
		t6 = (h6 + off) % (6 * UNIT);
		if (t6 < UNIT)
			c = p * UNIT + (q - p) * t6;
		else if (t6 < 3 * UNIT)
			c = q * UNIT;
		else if (t6 < 4 * UNIT)
			c = p * UNIT + (q - p) * (4 * UNIT - t6);
		else
			c = p * UNIT;
		return q2f_to_byte(c);
	endfunction

	function automatic recolor_rgb_t recolor_predict(logic [COLOR_W-1:0] color);
		recolor_rgb_t res;
		longint r8, g8, b8, hi, lo, light, scaled, sat, mix, q, p, h6, v;
		r8 = widen_channel(color[4:0]);
		g8 = widen_channel(color[9:5]);
		b8 = widen_channel(color[14:10]);
		hi = r8;
		lo = r8;
		if (g8 > hi) hi = g8;
		if (b8 > hi) hi = b8;
		if (g8 < lo) lo = g8;
		if (b8 < lo) lo = b8;
		light  = ((hi + lo) * UNIT + 255) / 510;
		scaled = (light * longint'(gain_reg) + UNIT / 2) >>> FRAC;
		sat    = longint'(sat_reg);
		if (sat * 1000 < UNIT) begin
			v = (scaled * 255) >>> FRAC;
			if (v > 255) v = 255;
			res.red   = v[CHAN_W-1:0];
			res.green = v[CHAN_W-1:0];
			res.blue  = v[CHAN_W-1:0];
			return res;
		end
		mix = (scaled * sat + UNIT / 2) >>> FRAC;
		if (scaled < UNIT / 2)
			q = scaled + mix;
		else
			q = scaled + sat - mix;
		p  = 2 * scaled - q;
		h6 = (longint'(hue_reg) % UNIT) * 6;
		res.red   = hue_channel(p, q, h6, 2 * UNIT);
		res.green = hue_channel(p, q, h6, 0);
		res.blue  = hue_channel(p, q, h6, 4 * UNIT);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < 40)
			$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_HUE:  hue_reg  = data[HUE_W-1:0];
			CFG_SAT:  sat_reg  = data[SAT_W-1:0];
			CFG_GAIN: gain_reg = data[GAIN_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_color(logic [COLOR_W-1:0] color);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, color};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	function automatic logic [COLOR_W-1:0] random_color;
		logic [4:0] level;
		if ($urandom_range(7) == 0) begin
			level = 5'($urandom_range(31));
			return {level, level, level};
		end
		return COLOR_W'($urandom_range(32767));
	endfunction

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_rgb.size() == 0) begin
				report_mismatch("result with no item outstanding", m_tdata, 0);
			end else begin
				oldest_rgb = pending_rgb.pop_front();
				if (m_tdata[7:0] !== oldest_rgb.red)
					report_mismatch("red_out", m_tdata[7:0], oldest_rgb.red);
				if (m_tdata[15:8] !== oldest_rgb.green)
					report_mismatch("green_out", m_tdata[15:8], oldest_rgb.green);
				if (m_tdata[23:16] !== oldest_rgb.blue)
					report_mismatch("blue_out", m_tdata[23:16], oldest_rgb.blue);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_rgb.size());
			$display("rgb555_lightness_hue_recolor_unit verification failed");
			$finish;
		end
	end

	initial begin
		logic [COLOR_W-1:0] color;
		logic [HUE_W-1:0]   hue_pick;
		logic [SAT_W-1:0]   sat_pick;
		logic [GAIN_W-1:0]  gain_pick;
		int                 pick;

		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		cycle_count    = 0;
		mismatches     = 0;
		items_sent     = 0;
		results_seen   = 0;
		reg_writes     = 0;
		hue_reg        = '0;
		sat_reg        = '0;
		gain_reg       = GAIN_RESET;

		// Extremes, the grey threshold, ignored register index, over-range gain and saturation.
		directed_rows = '{
			'{12'd0,    13'd0,    13'd4096, 1'b0, 15'h0000, 1'b1, '{8'd0,   8'd0,   8'd0}},
			'{12'd0,    13'd0,    13'd4096, 1'b0, 15'h7FFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
			'{12'd0,    13'd0,    13'd4096, 1'b0, 15'h001F, 1'b1, '{8'd127, 8'd127, 8'd127}},
			'{12'd0,    13'd0,    13'd4096, 1'b1, 15'h001F, 1'b1, '{8'd127, 8'd127, 8'd127}},
			'{12'd0,    13'd4,    13'd4096, 1'b0, 15'h03E0, 1'b1, '{8'd127, 8'd127, 8'd127}},
			'{12'd0,    13'd5,    13'd4096, 1'b0, 15'h03E0, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd0,    13'd4096, 13'd4096, 1'b0, 15'h7FFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
			'{12'd0,    13'd4096, 13'd4096, 1'b0, 15'h0000, 1'b1, '{8'd0,   8'd0,   8'd0}},
			'{12'd0,    13'd4096, 13'd4096, 1'b0, 15'h001F, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd1365, 13'd4096, 13'd4096, 1'b0, 15'h4210, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd2730, 13'd4096, 13'd4096, 1'b0, 15'h56B5, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd4095, 13'd4096, 13'd4096, 1'b0, 15'h2D6B, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd4095, 13'd4096, 13'd0,    1'b0, 15'h7FFF, 1'b1, '{8'd0,   8'd0,   8'd0}},
			'{12'd4095, 13'd0,    13'd8191, 1'b0, 15'h7FFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
			'{12'd683,  13'd4096, 13'd8191, 1'b0, 15'h4631, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd2048, 13'd8191, 13'd4096, 1'b0, 15'h3DEF, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd3413, 13'd8191, 13'd8191, 1'b0, 15'h7FFF, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd2048, 13'd8191, 13'd8191, 1'b0, 15'h0001, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'd0,    13'd4096, 13'd2048, 1'b0, 15'h5294, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'hAAA,  13'h1555, 13'h0AAA, 1'b0, 15'h2AAA, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{12'h555,  13'h0AAA, 13'h1555, 1'b0, 15'h5555, 1'b0, '{8'd0,   8'd0,   8'd0}}
		};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].stray || directed_rows[i].hue != hue_reg ||
				directed_rows[i].sat != sat_reg || directed_rows[i].gain != gain_reg) begin
				wait_drained();
				if (directed_rows[i].hue != hue_reg)
					write_reg(CFG_HUE, CFG_W'(directed_rows[i].hue));
				if (directed_rows[i].sat != sat_reg)
					write_reg(CFG_SAT, directed_rows[i].sat);
				if (directed_rows[i].gain != gain_reg)
					write_reg(CFG_GAIN, directed_rows[i].gain);
				if (directed_rows[i].stray)
					write_reg(CFG_UNUSED, 13'h1FFF);
			end
			send_color(directed_rows[i].color);
			if (directed_rows[i].typed)
				pending_rgb.push_back(directed_rows[i].rgb);
			else
				pending_rgb.push_back(recolor_predict(directed_rows[i].color));
		end

		for (int set = 0; set < RANDOM_SETS; set++) begin
			wait_drained();
			pick = $urandom_range(3);
			hue_pick = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom_range(4095));
			pick = $urandom_range(5);
			case (pick)
				0: sat_pick = 13'd0;
				1: sat_pick = 13'd5;
				2: sat_pick = 13'd4096;
				3: sat_pick = 13'd8191;
				4: sat_pick = 13'($urandom_range(8191));
				default: sat_pick = 13'($urandom_range(4096));
			endcase
			pick = $urandom_range(3);
			gain_pick = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd8191 :
				(pick == 2) ? 13'd4096 : 13'($urandom_range(8191));
			write_reg(CFG_HUE, {1'($urandom_range(1)), hue_pick});
			write_reg(CFG_SAT, sat_pick);
			write_reg(CFG_GAIN, gain_pick);
			case (set % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			for (int n = 0; n < SET_ITEMS; n++) begin
				color = random_color();
				send_color(color);
				pending_rgb.push_back(recolor_predict(color));
			end
		end

		// Hold the output back long enough for the input to back up, then let it drain.
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 12;
		hold_left      = HOLD_CYCLES;
		for (int n = 0; n < BURST_ITEMS; n++) begin
			color = random_color();
			send_color(color);
			pending_rgb.push_back(recolor_predict(color));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (4 * SETTLE) @(posedge clk);

		$display("Ran %0d items and checked %0d results across %0d register writes,",
			items_sent, results_seen, reg_writes);
		$display("covering grey and coloured paths, gain and saturation extremes and stalls.");
		if (mismatches == 0 && pending_rgb.size() == 0) begin
			$display("rgb555_lightness_hue_recolor_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_rgb.size());
			$display("rgb555_lightness_hue_recolor_unit verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/rhr_pkg.sv
rtl/rhr_front.sv
rtl/rhr_queue.sv
rtl/rhr_back.sv
rtl/rgb555_lightness_hue_recolor_unit.sv
sim/tb_rgb555_lightness_hue_recolor_unit.sv
